### rtl/periodic_task_tick_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task tick scheduler
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold.
`define PTTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptts: same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PTTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptts: next-cycle check failed");

`endif

### rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the tick scheduler controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptts_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [NUM_SLOTS-1:0] slot_mask_t;

  // Action codes
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_CREATE  = 3'd1;
  localparam logic [2:0] ACT_DELETE  = 3'd2;
  localparam logic [2:0] ACT_SUSPEND = 3'd3;
  localparam logic [2:0] ACT_RESUME  = 3'd4;
  localparam logic [2:0] ACT_QUERY   = 3'd5;

  // Slot states
  localparam logic [1:0] ST_EMPTY     = 2'd0;
  localparam logic [1:0] ST_READY     = 2'd1;
  localparam logic [1:0] ST_SUSPENDED = 2'd2;
  localparam logic [1:0] ST_DELETED   = 2'd3;

  typedef struct packed {
    logic [2:0] action;
    logic [2:0] task_id;
    logic [7:0] period;
    logic [7:0] initial_delay;
  } in_word_t;

  typedef struct packed {
    logic [2:0] slot_id;
    logic       fired;
    logic [1:0] slot_state;
    logic       last;
  } out_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_CMD
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;       // latch word, snapshot fire mask, clear walk index
    logic walk_step;  // visit one slot
    logic cmd_exec;   // apply a slot command and report it
  } ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic in_tick;    // presented word is a tick
    logic in_cmd;     // presented word is a valid slot command
    logic walk_last;  // walk index is on the final slot
  } stat_t;

endpackage

### rtl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Table of periodic task slots with tick-driven countdowns and slot commands.
// ----------------------------------------------------------------------------
// Usage:
//   Present a word on in_word and raise start; the word is taken on the edge
//   where start is high and busy is low. busy stays high while the word is
//   being worked on, so start may simply be held until busy drops.
//   A tick walks all NUM_SLOTS slots, one slot per clock through a single
//   countdown decrementer, with busy high until the walk ends. Each slot
//   that fires yields one result word, in ascending slot order, in the
//   cycle after its visit; the word of the highest firing slot carries
//   last. A tick with no firing slot yields nothing.
//   Create, delete, suspend, resume and query pass through the execute
//   state: the single result (last set) is on the ports in the cycle
//   after it.
//   Unused actions and out-of-range slots are taken and dropped at once.
//   Each result sits on out_word for exactly one cycle with out_valid high;
//   the receiver cannot stall, so nothing is held back.
//   Synchronous reset empties every slot and clears countdowns and periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_tick_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ptts_pkg::in_word_t  in_word,
  output logic                out_valid,
  output ptts_pkg::out_word_t out_word
);

  // Command and status between sequencer and slot datapath
  ptts_pkg::ctl_t  ctl;
  ptts_pkg::stat_t stat;

  // Sequencer: decide walk versus command, hold busy while working
  ptts_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Slot table, shared decrementer and registered result word
  ptts_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

### rtl/ptts_ctrl.sv
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer: idle, slot walk for ticks, slot command execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  ptts_pkg::stat_t stat,
  output logic            busy,
  output ptts_pkg::ctl_t  ctl
);

  ptts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptts_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptts_pkg::S_IDLE: begin
        if (start && stat.in_tick) begin
          state_nxt = ptts_pkg::S_WALK;
        end else if (start && stat.in_cmd) begin
          state_nxt = ptts_pkg::S_CMD;
        end
      end
      ptts_pkg::S_WALK: begin
        if (stat.walk_last) begin
          state_nxt = ptts_pkg::S_IDLE;
        end
      end
      ptts_pkg::S_CMD: begin
        state_nxt = ptts_pkg::S_IDLE;
      end
      default: begin
        state_nxt = ptts_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = (state_r != ptts_pkg::S_IDLE);
    ctl.load      = (state_r == ptts_pkg::S_IDLE) && start;
    ctl.walk_step = (state_r == ptts_pkg::S_WALK);
    ctl.cmd_exec  = (state_r == ptts_pkg::S_CMD);
  end

endmodule

### rtl/ptts_dpath.sv
// ----------------------------------------------------------------------------
// ptts_dpath
// Slot table, walk index, shared countdown decrementer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_task_tick_scheduler_macros.svh"

module ptts_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  ptts_pkg::in_word_t  in_word,
  input  ptts_pkg::ctl_t      ctl,
  output ptts_pkg::stat_t     stat,
  output logic                out_valid,
  output ptts_pkg::out_word_t out_word
);

  logic [1:0] status_r [ptts_pkg::NUM_SLOTS];
  logic [1:0] status_nxt [ptts_pkg::NUM_SLOTS];
  logic [7:0] cd_r [ptts_pkg::NUM_SLOTS];
  logic [7:0] cd_nxt [ptts_pkg::NUM_SLOTS];
  logic [7:0] per_r [ptts_pkg::NUM_SLOTS];
  logic [7:0] per_nxt [ptts_pkg::NUM_SLOTS];

  ptts_pkg::in_word_t   word_r, word_nxt;
  ptts_pkg::slot_idx_t  idx_r, idx_nxt;
  ptts_pkg::slot_mask_t mask_r, mask_nxt;
  ptts_pkg::out_word_t  out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  ptts_pkg::slot_mask_t fire_now;
  ptts_pkg::slot_idx_t  tid;
  logic                 higher_fire;
  logic [1:0]           cmd_state;

  // Slots that will fire on a tick taken now
  always_comb begin
    for (int i = 0; i < ptts_pkg::NUM_SLOTS; i++) begin
      fire_now[i] = (status_r[i] == ptts_pkg::ST_READY) && (cd_r[i] == 8'd0);
    end
  end

  // Any later slot of the snapshot still to fire
  always_comb begin
    higher_fire = 1'b0;
    for (int j = 0; j < ptts_pkg::NUM_SLOTS; j++) begin
      if (mask_r[j] && (ptts_pkg::slot_idx_t'(j) > idx_r)) begin
        higher_fire = 1'b1;
      end
    end
  end

  assign tid = ptts_pkg::slot_idx_t'(word_r.task_id);

  always_comb begin
    stat.in_tick   = (in_word.action == ptts_pkg::ACT_TICK);
    stat.in_cmd    = (in_word.action >= ptts_pkg::ACT_CREATE) &&
                     (in_word.action <= ptts_pkg::ACT_QUERY) &&
                     (int'(in_word.task_id) < ptts_pkg::NUM_SLOTS);
    stat.walk_last = (idx_r == ptts_pkg::slot_idx_t'(ptts_pkg::NUM_SLOTS - 1));
  end

  always_comb begin
    unique case (word_r.action)
      ptts_pkg::ACT_CREATE:  cmd_state = ptts_pkg::ST_READY;
      ptts_pkg::ACT_DELETE:  cmd_state = ptts_pkg::ST_DELETED;
      ptts_pkg::ACT_SUSPEND: cmd_state = ptts_pkg::ST_SUSPENDED;
      ptts_pkg::ACT_RESUME:  cmd_state = ptts_pkg::ST_READY;
      default:               cmd_state = status_r[tid];
    endcase
  end

  always_comb begin
    status_nxt    = status_r;
    cd_nxt        = cd_r;
    per_nxt       = per_r;
    word_nxt      = word_r;
    idx_nxt       = idx_r;
    mask_nxt      = mask_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;

    if (ctl.load) begin
      word_nxt = in_word;
      idx_nxt  = '0;
      mask_nxt = fire_now;
    end

    if (ctl.walk_step) begin
      // Visit one slot: fire and reload, or count down
      if (status_r[idx_r] == ptts_pkg::ST_READY) begin
        if (cd_r[idx_r] == 8'd0) begin
          cd_nxt[idx_r]      = (per_r[idx_r] == 8'd0) ? 8'd0 : per_r[idx_r] - 8'd1;
          out_valid_nxt      = 1'b1;
          out_nxt.slot_id    = 3'(idx_r);
          out_nxt.fired      = 1'b1;
          out_nxt.slot_state = ptts_pkg::ST_READY;
          out_nxt.last       = !higher_fire;
        end else begin
          cd_nxt[idx_r] = cd_r[idx_r] - 8'd1;
        end
      end
      idx_nxt = idx_r + ptts_pkg::slot_idx_t'(1);
    end

    if (ctl.cmd_exec) begin
      if (word_r.action == ptts_pkg::ACT_CREATE) begin
        cd_nxt[tid]  = word_r.initial_delay;
        per_nxt[tid] = (word_r.period == 8'd0) ? 8'd1 : word_r.period;
      end
      status_nxt[tid]    = cmd_state;
      out_valid_nxt      = 1'b1;
      out_nxt.slot_id    = word_r.task_id;
      out_nxt.fired      = 1'b0;
      out_nxt.slot_state = cmd_state;
      out_nxt.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptts_pkg::NUM_SLOTS; i++) begin
        status_r[i] <= ptts_pkg::ST_EMPTY;
        cd_r[i]     <= 8'd0;
        per_r[i]    <= 8'd0;
      end
      idx_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      status_r    <= status_nxt;
      cd_r        <= cd_nxt;
      per_r       <= per_nxt;
      idx_r       <= idx_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `PTTS_ASSERT_NEXT(a_cmd_reports, clk, rst_n, ctl.cmd_exec,
                    out_valid_r && !out_r.fired && out_r.last)
  `PTTS_ASSERT_NEXT(a_walk_ends_last, clk, rst_n, ctl.walk_step && stat.walk_last,
                    !out_valid_r || out_r.last)
  `PTTS_ASSERT_NEXT(a_fire_matches_snapshot, clk, rst_n,
                    ctl.walk_step && !mask_r[idx_r], !out_valid_r)
  `PTTS_ASSERT_NOW(a_no_step_and_cmd, clk, rst_n, ctl.walk_step, !ctl.cmd_exec)

endmodule

### tb/periodic_task_tick_scheduler_tb.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_tb
// Self-checking bench for the tick scheduler. A directed table covers the
// empty table, unused actions, field extremes, suspend/resume/delete, resume
// of a never-created slot and a tick where every slot fires. Random words
// follow. A slot table model predicts results not written out by hand, and a
// scoreboard checks each strobed result word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_tb;

  // Action codes the block takes and drops without a result
  localparam logic [2:0] ACT_UNUSED_A = 3'd6;
  localparam logic [2:0] ACT_UNUSED_B = 3'd7;

  localparam int RAND_WORDS   = 300;
  // Span of the plan where the sender never idles
  localparam int QUIET_LO     = 140;
  localparam int QUIET_HI     = 210;
  // A tick walks every slot, and its last result trails the walk through the result register
  localparam int DRAIN_CYCLES = 2 * ptts_pkg::NUM_SLOTS + 4;

  // One planned word; typed rows carry their result written out by hand
  typedef struct {
    ptts_pkg::in_word_t  word;
    bit                  typed;
    bit                  has_res;
    ptts_pkg::out_word_t res;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ptts_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  ptts_pkg::out_word_t out_word;

  periodic_task_tick_scheduler u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow slot table
  logic [1:0] slot_st  [ptts_pkg::NUM_SLOTS];
  logic [7:0] slot_cnt [ptts_pkg::NUM_SLOTS];
  logic [7:0] slot_per [ptts_pkg::NUM_SLOTS];

  plan_row_t           word_plan[$];
  ptts_pkg::out_word_t due_results[$];
  int                  err_count = 0;
  bit                  all_sent  = 1'b0;

  // Advance the shadow table by one word; queue its results when keep is set
  function automatic void step_slots(input ptts_pkg::in_word_t w, input bit keep);
    ptts_pkg::out_word_t hits[ptts_pkg::NUM_SLOTS];
    int                  n;
    ptts_pkg::out_word_t r;
    n = 0;
    if (w.action == ptts_pkg::ACT_TICK) begin
      // Visit slots in ascending order; only ready slots count down or fire
      for (int i = 0; i < ptts_pkg::NUM_SLOTS; i++) begin
        if (slot_st[i] == ptts_pkg::ST_READY) begin
          if (slot_cnt[i] == 8'd0) begin
            slot_cnt[i] = (slot_per[i] == 8'd0) ? 8'd0 : slot_per[i] - 8'd1;
            hits[n] = '{slot_id: 3'(i), fired: 1'b1,
                        slot_state: ptts_pkg::ST_READY, last: 1'b0};
            n++;
          end else begin
            slot_cnt[i] = slot_cnt[i] - 8'd1;
          end
        end
      end
      if (n > 0) hits[n-1].last = 1'b1;
      if (keep) begin
        for (int k = 0; k < n; k++) due_results.push_back(hits[k]);
      end
    end else if (w.action <= ptts_pkg::ACT_QUERY &&
                 int'(w.task_id) < ptts_pkg::NUM_SLOTS) begin
      case (w.action)
        ptts_pkg::ACT_CREATE: begin
          slot_cnt[w.task_id] = w.initial_delay;
          slot_per[w.task_id] = (w.period == 8'd0) ? 8'd1 : w.period;
          slot_st[w.task_id]  = ptts_pkg::ST_READY;
        end
        ptts_pkg::ACT_DELETE:  slot_st[w.task_id] = ptts_pkg::ST_DELETED;
        ptts_pkg::ACT_SUSPEND: slot_st[w.task_id] = ptts_pkg::ST_SUSPENDED;
        ptts_pkg::ACT_RESUME:  slot_st[w.task_id] = ptts_pkg::ST_READY;
        default: ;
      endcase
      r = '{slot_id: w.task_id, fired: 1'b0, slot_state: slot_st[w.task_id],
            last: 1'b1};
      if (keep) due_results.push_back(r);
    end
  endfunction

  // Append a plan row; typed rows expect one command result or none
  function automatic void add_row(input logic [2:0] act, input logic [2:0] id,
                                  input logic [7:0] per, input logic [7:0] dly,
                                  input bit typed, input bit has_res,
                                  input logic [1:0] st);
    plan_row_t row;
    row.word    = '{action: act, task_id: id, period: per, initial_delay: dly};
    row.typed   = typed;
    row.has_res = has_res;
    row.res     = '{slot_id: id, fired: 1'b0, slot_state: st, last: 1'b1};
    word_plan.push_back(row);
  endfunction

  // Random word: mostly ticks and creates with short periods and delays,
  // so slots fire often; the rest are slot commands and dropped actions
  function automatic void add_random_row();
    int         pick;
    logic [2:0] act;
    logic [7:0] per;
    logic [7:0] dly;
    pick = $urandom_range(99);
    per  = 8'($urandom_range(255));
    dly  = 8'($urandom_range(255));
    if (pick < 45)      act = ptts_pkg::ACT_TICK;
    else if (pick < 65) act = ptts_pkg::ACT_CREATE;
    else if (pick < 73) act = ptts_pkg::ACT_DELETE;
    else if (pick < 81) act = ptts_pkg::ACT_SUSPEND;
    else if (pick < 89) act = ptts_pkg::ACT_RESUME;
    else if (pick < 95) act = ptts_pkg::ACT_QUERY;
    else                act = ($urandom_range(1) == 0) ? ACT_UNUSED_A : ACT_UNUSED_B;
    if (act == ptts_pkg::ACT_CREATE) begin
      if ($urandom_range(99) < 80) per = 8'($urandom_range(6));
      if ($urandom_range(99) < 80) dly = 8'($urandom_range(8));
    end
    add_row(act, 3'($urandom_range(7)), per, dly, 1'b0, 1'b0, ptts_pkg::ST_EMPTY);
  endfunction

  // Build the plan: directed table first, random words after
  initial begin
    for (int i = 0; i < ptts_pkg::NUM_SLOTS; i++) begin
      slot_st[i]  = ptts_pkg::ST_EMPTY;
      slot_cnt[i] = 8'd0;
      slot_per[i] = 8'd0;
    end

    // Empty table: a tick yields nothing, queries report empty
    add_row(ptts_pkg::ACT_TICK,    3'd0, 8'h00, 8'h00, 1'b1, 1'b0, ptts_pkg::ST_EMPTY);
    add_row(ptts_pkg::ACT_QUERY,   3'd0, 8'h00, 8'h00, 1'b1, 1'b1, ptts_pkg::ST_EMPTY);
    add_row(ptts_pkg::ACT_QUERY,   3'd7, 8'hff, 8'hff, 1'b1, 1'b1, ptts_pkg::ST_EMPTY);
    // Unused actions are dropped
    add_row(ACT_UNUSED_A,          3'd3, 8'h00, 8'h00, 1'b1, 1'b0, ptts_pkg::ST_EMPTY);
    add_row(ACT_UNUSED_B,          3'd7, 8'hff, 8'hff, 1'b1, 1'b0, ptts_pkg::ST_EMPTY);
    // Creates at the field extremes; period zero gets clamped to one
    add_row(ptts_pkg::ACT_CREATE,  3'd0, 8'h00, 8'h00, 1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_CREATE,  3'd7, 8'hff, 8'hff, 1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_CREATE,  3'd3, 8'd3,  8'd1,  1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_TICK,    3'd0, 8'h00, 8'h00, 1'b0, 1'b0, ptts_pkg::ST_EMPTY);
    add_row(ptts_pkg::ACT_TICK,    3'd5, 8'ha5, 8'h5a, 1'b0, 1'b0, ptts_pkg::ST_EMPTY);
    // Suspended slot holds its countdown across a tick
    add_row(ptts_pkg::ACT_SUSPEND, 3'd3, 8'h00, 8'h00, 1'b1, 1'b1,
            ptts_pkg::ST_SUSPENDED);
    add_row(ptts_pkg::ACT_TICK,    3'd0, 8'h00, 8'h00, 1'b0, 1'b0, ptts_pkg::ST_EMPTY);
    add_row(ptts_pkg::ACT_RESUME,  3'd3, 8'h00, 8'h00, 1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_DELETE,  3'd0, 8'h00, 8'h00, 1'b1, 1'b1,
            ptts_pkg::ST_DELETED);
    add_row(ptts_pkg::ACT_QUERY,   3'd0, 8'h00, 8'h00, 1'b1, 1'b1,
            ptts_pkg::ST_DELETED);
    // Resume of a never-created slot: stored period zero, fires every tick
    add_row(ptts_pkg::ACT_RESUME,  3'd5, 8'h00, 8'h00, 1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_TICK,    3'd0, 8'h00, 8'h00, 1'b0, 1'b0, ptts_pkg::ST_EMPTY);
    // Ready every slot at countdown zero, then tick for the full burst
    add_row(ptts_pkg::ACT_CREATE,  3'd1, 8'd1,  8'd0,  1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_CREATE,  3'd2, 8'd1,  8'd0,  1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_CREATE,  3'd4, 8'd1,  8'd0,  1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_CREATE,  3'd6, 8'd1,  8'd0,  1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_RESUME,  3'd0, 8'h00, 8'h00, 1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_CREATE,  3'd7, 8'd1,  8'd0,  1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_CREATE,  3'd3, 8'd1,  8'd0,  1'b1, 1'b1, ptts_pkg::ST_READY);
    add_row(ptts_pkg::ACT_TICK,    3'd7, 8'hff, 8'hff, 1'b0, 1'b0, ptts_pkg::ST_EMPTY);

    for (int i = 0; i < RAND_WORDS; i++) add_random_row();
  end

  // Hold reset low from time zero, then release it for good
  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Scoreboard and sender share one clocked process. All inputs of the
  // block and all sampled outputs are read before this edge's updates land.
  plan_row_t cur_row;
  bit        word_pending = 1'b0;
  int        row_ptr = 0;

  always @(posedge clk) begin : sched_bench
    bit                  take;
    bit                  idle;
    ptts_pkg::out_word_t exp_w;

    // Check each strobed result against the oldest expectation
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $error("unexpected result word: slot_id=%0d fired=%0d slot_state=%0d last=%0d",
               out_word.slot_id, out_word.fired, out_word.slot_state, out_word.last);
        err_count++;
      end else begin
        exp_w = due_results.pop_front();
        if (out_word.slot_id !== exp_w.slot_id) begin
          $error("slot_id: expected %0d, got %0d", exp_w.slot_id, out_word.slot_id);
          err_count++;
        end
        if (out_word.fired !== exp_w.fired) begin
          $error("fired: expected %0d, got %0d", exp_w.fired, out_word.fired);
          err_count++;
        end
        if (out_word.slot_state !== exp_w.slot_state) begin
          $error("slot_state: expected %0d, got %0d", exp_w.slot_state, out_word.slot_state);
          err_count++;
        end
        if (out_word.last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, out_word.last);
          err_count++;
        end
      end
    end

    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // A word moves on an edge where start is high and busy is low
      take = start && !busy;
      if (take) begin
        // Typed rows expect what is written in the table; still advance the
        // shadow table so later predicted rows see the right state
        step_slots(cur_row.word, !cur_row.typed);
        if (cur_row.typed && cur_row.has_res) due_results.push_back(cur_row.res);
        word_pending = 1'b0;
      end

      // Idle at random outside the quiet span, on any phase of the work
      idle = !(row_ptr >= QUIET_LO && row_ptr < QUIET_HI) && ($urandom_range(99) < 28);

      if (!word_pending) begin
        if (row_ptr < word_plan.size()) begin
          // Advance to the next planned word
          cur_row      = word_plan[row_ptr];
          row_ptr++;
          word_pending = 1'b1;
          in_word <= cur_row.word;
          start   <= !idle;
        end else begin
          all_sent = 1'b1;
          start   <= 1'b0;
        end
      end else begin
        // Hold the word; drop start now and then, busy or not
        start <= !idle;
      end
    end
  end

  // Drain: wait for every expected word, then let a full walk pass
  initial begin
    while (!(all_sent && due_results.size() == 0)) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_results.size() != 0) begin
      $error("%0d expected result words never arrived", due_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("periodic_task_tick_scheduler: match");
    end else begin
      $display("periodic_task_tick_scheduler: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("periodic_task_tick_scheduler: mismatch");
    $finish;
  end

endmodule
